// ===== design/tcon_pkg.sv =====
// Shared types and constants for the text console cursor and scroll block.
package tcon_pkg;

	localparam int COLUMNS_DFLT = 80;
	localparam int ROWS_DFLT    = 25;

	localparam int CUR_W  = 11;
	localparam int CELL_W = 16;

	localparam logic       CMD_PUT  = 1'b0;
	localparam logic       CMD_READ = 1'b1;

	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] ATTR_RESET   = 8'h07;

	typedef struct packed {
		logic             cmd;
		logic [7:0]       char_code;
		logic [CUR_W-1:0] cell_index;
	} tcon_in_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_value;
		logic [CUR_W-1:0]  cursor;
		logic              scrolled;
	} tcon_out_t;

endpackage

// ===== design/tcon_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tcon_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== design/text_console_cursor_and_scroll_top.sv =====
// Text console: screen memory, cursor tracking and scrolling under one sequencer.
//
// The screen is ROWS x COLUMNS cells of 16 bits (attribute high, character low) held in
// one RAM with a single write port and a registered read port. After reset a clearing
// pass writes a blank to every cell, one cell per cycle; no item is taken during it,
// while attribute writes are taken at any time. A read passes the read state and the
// done state (load the result register); a put, newline or backspace passes the put
// state (write the character, for a put only), the blank state (blank the cell at the
// cursor) and the done state. A put that scrolls copies the rows up one cell per cycle
// through the RAM read port, then blanks the bottom row one cell per cycle. The result
// register lets the next item be accepted while a result still waits to be taken.
module text_console_cursor_and_scroll_top
	import tcon_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DFLT,
	parameter int ROWS    = ROWS_DFLT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  tcon_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output tcon_out_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [7:0] cfg_data
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int COL_W = $clog2(COLUMNS);
	localparam int ROW_W = $clog2(ROWS);

	localparam logic [AW-1:0]    COLS_A    = AW'(COLUMNS);
	localparam logic [AW-1:0]    LAST_A    = AW'(CELLS - 1);
	localparam logic [AW-1:0]    BOTROW_A  = AW'(CELLS - COLUMNS);
	localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
	localparam logic [CELL_W-1:0] RESET_BLANK = {ATTR_RESET, CH_SPACE};

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PUT,
		ST_RD,
		ST_SCR_COPY,
		ST_SCR_BLANK,
		ST_BLANK,
		ST_DONE
	} st_t;

	st_t              state_q;
	tcon_in_t         item_q;
	logic [7:0]       attr_q;
	logic [AW-1:0]    pos_q;
	logic [AW-1:0]    base_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [AW-1:0]    cnt_q;
	logic             scrolled_q;
	logic             cp_valid_s1;
	logic [AW-1:0]    cp_addr_s1;
	logic             out_valid_q;
	tcon_out_t        out_q;

	logic [AW-1:0]    nxt_pos;
	logic [AW-1:0]    nxt_base;
	logic [COL_W-1:0] nxt_col;
	logic [ROW_W-1:0] nxt_row;
	logic             nxt_scroll;

	logic [AW+CUR_W-1:0] idx_wide;
	logic [AW+CUR_W-1:0] pos_wide;
	logic                idx_in_range;
	logic [AW-1:0]       item_addr;

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [CELL_W-1:0] wr_data;
	logic [AW-1:0]     rd_addr;
	logic [CELL_W-1:0] rd_data;

	logic is_nl;
	logic is_bs;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign is_nl = (item_q.char_code == CH_NEWLINE);
	assign is_bs = (item_q.char_code == CH_BACKSPACE);

	assign idx_wide     = {{AW{1'b0}}, item_q.cell_index};
	assign idx_in_range = (idx_wide < (AW + CUR_W)'(CELLS));
	assign item_addr    = idx_wide[AW-1:0];
	assign pos_wide     = {{CUR_W{1'b0}}, pos_q};

	// Next cursor; a move off the bottom row scrolls and lands on the bottom row start.
	always_comb begin
		nxt_pos    = pos_q;
		nxt_base   = base_q;
		nxt_col    = col_q;
		nxt_row    = row_q;
		nxt_scroll = 1'b0;
		if (is_nl || (!is_bs && col_q == COL_LAST)) begin
			nxt_col = '0;
			if (row_q == ROW_LAST) begin
				nxt_scroll = 1'b1;
				nxt_pos    = base_q;
			end else begin
				nxt_pos  = base_q + COLS_A;
				nxt_base = base_q + COLS_A;
				nxt_row  = row_q + 1'b1;
			end
		end else if (is_bs) begin
			if (pos_q != '0) begin
				nxt_pos = pos_q - 1'b1;
				if (col_q == '0) begin
					nxt_col  = COL_LAST;
					nxt_row  = row_q - 1'b1;
					nxt_base = base_q - COLS_A;
				end else begin
					nxt_col = col_q - 1'b1;
				end
			end
		end else begin
			nxt_pos = pos_q + 1'b1;
			nxt_col = col_q + 1'b1;
		end
	end

	// The copy write of a cell read in the previous cycle takes the write port first.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = {attr_q, CH_SPACE};
		if (cp_valid_s1) begin
			wr_en   = 1'b1;
			wr_addr = cp_addr_s1;
			wr_data = rd_data;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					wr_en   = 1'b1;
					wr_addr = cnt_q;
					wr_data = RESET_BLANK;
				end
				ST_PUT: begin
					wr_en   = !is_nl && !is_bs;
					wr_data = {attr_q, item_q.char_code};
				end
				ST_SCR_BLANK: begin
					wr_en   = 1'b1;
					wr_addr = cnt_q;
				end
				ST_BLANK: begin
					wr_en = 1'b1;
				end
				default: begin
					wr_en = 1'b0;
				end
			endcase
		end
	end

	assign rd_addr = (state_q == ST_SCR_COPY) ? cnt_q : item_addr;

	tcon_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_screen (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			item_q      <= '0;
			attr_q      <= ATTR_RESET;
			pos_q       <= '0;
			base_q      <= '0;
			col_q       <= '0;
			row_q       <= '0;
			cnt_q       <= '0;
			scrolled_q  <= 1'b0;
			cp_valid_s1 <= 1'b0;
			cp_addr_s1  <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_valid) begin
				attr_q <= cfg_data;
			end
			// In the done state the result register is reloaded below instead.
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			cp_valid_s1 <= (state_q == ST_SCR_COPY);
			cp_addr_s1  <= cnt_q - COLS_A;

			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_A) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						item_q     <= in_data;
						scrolled_q <= 1'b0;
						state_q    <= (in_data.cmd == CMD_READ) ? ST_RD : ST_PUT;
					end
				end
				ST_RD: begin
					state_q <= ST_DONE;
				end
				ST_PUT: begin
					pos_q      <= nxt_pos;
					base_q     <= nxt_base;
					col_q      <= nxt_col;
					row_q      <= nxt_row;
					scrolled_q <= nxt_scroll;
					if (nxt_scroll) begin
						cnt_q   <= COLS_A;
						state_q <= ST_SCR_COPY;
					end else begin
						state_q <= ST_BLANK;
					end
				end
				ST_SCR_COPY: begin
					if (cnt_q == LAST_A) begin
						cnt_q   <= BOTROW_A;
						state_q <= ST_SCR_BLANK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SCR_BLANK: begin
					// Hold while the last copy write still owns the write port.
					if (!cp_valid_s1) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == LAST_A) begin
							state_q <= ST_BLANK;
						end
					end
				end
				ST_BLANK: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_q.cursor   <= pos_wide[CUR_W-1:0];
						out_q.scrolled <= scrolled_q;
						if (item_q.cmd == CMD_READ && idx_in_range) begin
							out_q.cell_value <= rd_data;
						end else begin
							out_q.cell_value <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the text console: cursor moves, scrolling, cell reads and attribute writes.
`timescale 1ns / 100ps

module testbench;
	import tcon_pkg::*;

	localparam int CELLS      = COLUMNS_DFLT * ROWS_DFLT;
	localparam int LAST_ROW   = CELLS - COLUMNS_DFLT;
	localparam int HOLD_BEATS = 300;
	localparam int PRINT_CAP  = 30;

	typedef struct packed {
		tcon_in_t  item;
		int        reps;
		bit        typed;
		tcon_out_t want;
	} stim_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	tcon_in_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	tcon_out_t out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic [7:0] cfg_data = '0;

	// Shadow copy of the console state.
	logic [15:0] screen_m [CELLS];
	int unsigned cursor_m;
	logic [7:0]  attr_m;

	tcon_out_t pending_results [$];
	int        mismatches = 0;
	int        items_sent = 0;
	int        reads_sent = 0;
	int        reads_off_screen = 0;
	int        scroll_count = 0;
	int        attr_writes = 0;
	int        hold_left = 0;
	bit        steady = 1'b0;

	// Opening stimulus. Rows with typed set carry a result that is plain by inspection.
	stim_row_t opening_rows [18] = '{
		'{'{CMD_READ, 8'h00, 11'd0},    1, 1'b1, '{16'h0720, 11'd0, 1'b0}},
		'{'{CMD_READ, 8'h00, 11'd1999}, 1, 1'b1, '{16'h0720, 11'd0, 1'b0}},
		'{'{CMD_READ, 8'h00, 11'd2000}, 1, 1'b1, '{16'h0000, 11'd0, 1'b0}},
		'{'{CMD_READ, 8'hFF, 11'd2047}, 1, 1'b1, '{16'h0000, 11'd0, 1'b0}},
		'{'{CMD_PUT, CH_BACKSPACE, 11'd0}, 1, 1'b1, '{16'h0000, 11'd0, 1'b0}},
		'{'{CMD_PUT, 8'h41, 11'd2047},  1, 1'b1, '{16'h0000, 11'd1, 1'b0}},
		'{'{CMD_PUT, 8'hFF, 11'd0},     1, 1'b1, '{16'h0000, 11'd2, 1'b0}},
		'{'{CMD_PUT, 8'h00, 11'd0},     1, 1'b1, '{16'h0000, 11'd3, 1'b0}},
		'{'{CMD_READ, 8'h00, 11'd1},    1, 1'b1, '{16'h07FF, 11'd3, 1'b0}},
		'{'{CMD_READ, 8'h00, 11'd2},    1, 1'b1, '{16'h0700, 11'd3, 1'b0}},
		'{'{CMD_READ, 8'h00, 11'd3},    1, 1'b1, '{16'h0720, 11'd3, 1'b0}},
		'{'{CMD_PUT, CH_NEWLINE, 11'd0},   1, 1'b1, '{16'h0000, 11'd80, 1'b0}},
		'{'{CMD_PUT, CH_BACKSPACE, 11'd0}, 1, 1'b1, '{16'h0000, 11'd79, 1'b0}},
		'{'{CMD_READ, 8'h00, 11'd80},   1, 1'b0, '0},
		'{'{CMD_PUT, CH_NEWLINE, 11'd0},   24, 1'b0, '0},
		'{'{CMD_PUT, CH_NEWLINE, 11'd0},   1, 1'b1, '{16'h0000, 11'd1920, 1'b1}},
		'{'{CMD_READ, 8'h00, 11'd0},    1, 1'b0, '0},
		'{'{CMD_READ, 8'h00, 11'd1920}, 1, 1'b0, '0}
	};

	text_console_cursor_and_scroll_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_CAP) $display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Applies one item to the shadow console and returns the result it should produce.
	function automatic tcon_out_t console_step(input tcon_in_t it);
		tcon_out_t   r;
		int unsigned pos;
		r = '0;
		pos = cursor_m;
		if (it.cmd == CMD_READ) begin
			reads_sent++;
			if (it.cell_index < CELLS) r.cell_value = screen_m[it.cell_index];
			else reads_off_screen++;
		end else begin
			if (it.char_code == CH_NEWLINE) begin
				pos += COLUMNS_DFLT - pos % COLUMNS_DFLT;
			end else if (it.char_code == CH_BACKSPACE) begin
				if (pos > 0) pos--;
			end else begin
				screen_m[pos] = {attr_m, it.char_code};
				pos++;
			end
			if (pos >= CELLS) begin
				for (int i = 0; i < LAST_ROW; i++) screen_m[i] = screen_m[i + COLUMNS_DFLT];
				for (int i = LAST_ROW; i < CELLS; i++) screen_m[i] = {attr_m, CH_SPACE};
				pos -= COLUMNS_DFLT;
				r.scrolled = 1'b1;
				scroll_count++;
			end
			screen_m[pos] = {attr_m, CH_SPACE};
			cursor_m = pos;
		end
		r.cursor = cursor_m[CUR_W-1:0];
		return r;
	endfunction

	function automatic tcon_in_t random_item(input int newline_pct);
		tcon_in_t it;
		int       pick;
		it.cmd = ($urandom_range(99) < 30) ? CMD_READ : CMD_PUT;
		it.char_code = 8'($urandom_range(255));
		if ($urandom_range(99) < 85) it.cell_index = 11'($urandom_range(CELLS - 1));
		else it.cell_index = 11'($urandom_range(2047, CELLS));
		if (it.cmd == CMD_PUT) begin
			pick = $urandom_range(99);
			if (pick < newline_pct) it.char_code = CH_NEWLINE;
			else if (pick < newline_pct + 8) it.char_code = CH_BACKSPACE;
		end
		return it;
	endfunction

	// Called at a rising edge; returns at the rising edge where the beat is taken.
	task automatic send_item(input tcon_in_t it, input bit typed, input tcon_out_t want);
		tcon_out_t got;
		if (!steady) begin
			while ($urandom_range(99) < 32) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(negedge clk); while (!in_ready);
		got = console_step(it);
		pending_results.push_back(typed ? want : got);
		items_sent++;
		@(posedge clk);
	endtask

	task automatic write_attribute(input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(negedge clk); while (!cfg_ready);
		attr_m = value;
		attr_writes++;
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Output side: random back-pressure, plus one long hold-off on request.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= steady || ($urandom_range(99) >= 32);
			end
		end
	end

	// Handshakes are sampled on the falling edge, where every signal is settled.
	always @(negedge clk) begin : result_check
		tcon_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat arrived with nothing expected");
			end else begin
				want = pending_results.pop_front();
				if (out_data.cell_value !== want.cell_value)
					report_mismatch($sformatf("cell_value got %h want %h",
						out_data.cell_value, want.cell_value));
				if (out_data.cursor !== want.cursor)
					report_mismatch($sformatf("cursor got %0d want %0d",
						out_data.cursor, want.cursor));
				if (out_data.scrolled !== want.scrolled)
					report_mismatch($sformatf("scrolled got %b want %b",
						out_data.scrolled, want.scrolled));
			end
		end
	end

	initial begin : stimulus
		int         phase_len [4];
		int         newline_pct [4];
		logic [7:0] attr_pick [4];
		phase_len   = '{400, 300, 400, 350};
		newline_pct = '{10, 10, 25, 6};
		attr_pick   = '{8'hFF, 8'h00, 8'($urandom_range(255)), 8'($urandom_range(255))};
		attr_m   = ATTR_RESET;
		cursor_m = 0;
		for (int i = 0; i < CELLS; i++) screen_m[i] = {ATTR_RESET, CH_SPACE};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// The first beat is only taken once the clearing pass after reset is done.
		foreach (opening_rows[r])
			repeat (opening_rows[r].reps)
				send_item(opening_rows[r].item, opening_rows[r].typed, opening_rows[r].want);
		in_valid <= 1'b0;
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			write_attribute(attr_pick[p]);
			steady = (p == 1);
			for (int n = 0; n < phase_len[p]; n++) begin
				if (p == 0 && n == 100) hold_left = HOLD_BEATS;
				send_item(random_item(newline_pct[p]), 1'b0, '0);
			end
			in_valid <= 1'b0;
			steady = 1'b0;
			wait_drained();
		end

		repeat (40) @(posedge clk);
		$display("Covered %0d items (%0d reads, %0d beyond the screen) and %0d scrolls",
			items_sent, reads_sent, reads_off_screen, scroll_count);
		$display("across %0d attribute settings, with one long output hold-off.", attr_writes);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("%0d mismatches found.", mismatches);
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#150_000_000;
		$display("Run timed out with %0d results outstanding.", pending_results.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
